// File: sv/stfd_pkg.sv
// Shared types and constants for the sport telemetry frame decoder.
// Used by stfd_deframer, sport_telemetry_frame_decoder and the bench; no dependencies.
package stfd_pkg;

  // Framing bytes.
  localparam logic [7:0] StartByte  = 8'h7E;
  localparam logic [7:0] EscapeByte = 8'h7D;
  localparam logic [7:0] EscapeXor  = 8'h20;
  localparam logic [7:0] DataFrame  = 8'h10;

  // Frame bytes that are kept; any byte past these is counted only.
  localparam int unsigned StoreBytes = 8;
  localparam int unsigned StoreIdxW  = $clog2(StoreBytes);

  // Data types with special handling.
  localparam logic [15:0] TypeGpsPos   = 16'h0800;
  localparam logic [15:0] TypeGpsState = 16'h0410;

  // GPS position word layout.
  localparam logic [31:0] GpsMagMask = 32'h3FFF_FFFF;
  localparam int unsigned GpsNegBit  = 30;
  localparam int unsigned GpsLonBit  = 31;

  // Satellite count and fix threshold.
  localparam logic [31:0] FixThreshold = 32'd1000;
  localparam logic [6:0]  SatModulus   = 7'd100;
  // floor(x / 100) = (x * Div100Mul) >> Div100Shift for every 32-bit x.
  localparam logic [31:0] Div100Mul   = 32'h51EB_851F;
  localparam int unsigned Div100Shift = 37;
  localparam int unsigned QuotW       = 64 - Div100Shift;

  // A completed frame as handed from the deframer to the result pipeline.
  typedef struct packed {
    logic        done;
    logic        is_data;
    logic [7:0]  sensor_id;
    logic [15:0] data_type;
    logic [31:0] raw_value;
  } frame_t;

  function automatic logic is_known_type(input logic [15:0] t);
    logic known;
    known = 1'b0;
    case (t) inside
      16'h0210, 16'h0910, 16'h0110, 16'h0830, 16'h0100, 16'h0820,
      16'h0420, 16'h0600, 16'h0800, 16'h0200, 16'h0840, 16'hF101,
      16'h0400, 16'h0410, 16'h0430, 16'h0440, 16'h0A00: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

endpackage

// File: sv/stfd_deframer.sv
// Byte-level deframer: start byte hunt, escape removal and frame collection.
// Depends on stfd_pkg.
module stfd_deframer import stfd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output frame_t     frame_o
);

  localparam int unsigned CntW = $clog2(FRAME_BYTES + 1);
  localparam logic [CntW-1:0] FrameLen = CntW'(FRAME_BYTES);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_DATA,
    MODE_ESC
  } mode_e;

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      store_q [StoreBytes];
  logic [7:0]      store_d [StoreBytes];
  logic            wr_en;
  logic [7:0]      wr_byte;

  always_comb begin
    mode_d  = mode_q;
    cnt_d   = cnt_q;
    wr_en   = 1'b0;
    wr_byte = byte_i;
    case (mode_q)
      MODE_IDLE: begin
        cnt_d = '0;
        if (byte_i == StartByte) begin
          mode_d = MODE_DATA;
        end
      end
      MODE_DATA: begin
        if (byte_i == EscapeByte) begin
          mode_d = MODE_ESC;
        end else if (byte_i == StartByte) begin
          cnt_d = '0;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      MODE_ESC: begin
        wr_en   = 1'b1;
        wr_byte = byte_i ^ EscapeXor;
        cnt_d   = cnt_q + 1'b1;
        mode_d  = MODE_DATA;
      end
      default: begin
        mode_d = MODE_IDLE;
        cnt_d  = '0;
      end
    endcase
    if (cnt_d == FrameLen) begin
      mode_d = MODE_IDLE;
    end
  end

  // Bytes past the store depth (when FRAME_BYTES exceeds it) are counted but dropped.
  always_comb begin
    for (int i = 0; i < StoreBytes; i++) begin
      store_d[i] = store_q[i];
    end
    if (wr_en && (cnt_q < CntW'(StoreBytes))) begin
      store_d[cnt_q[StoreIdxW-1:0]] = wr_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      cnt_q  <= '0;
    end else if (accept_i) begin
      mode_q <= mode_d;
      cnt_q  <= (cnt_d == FrameLen) ? '0 : cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      for (int i = 0; i < StoreBytes; i++) begin
        store_q[i] <= store_d[i];
      end
    end
  end

  assign frame_o.done      = accept_i && (cnt_d == FrameLen);
  assign frame_o.is_data   = (store_d[1] == DataFrame);
  assign frame_o.sensor_id = store_d[0];
  assign frame_o.data_type = {store_d[3], store_d[2]};
  assign frame_o.raw_value = {store_d[7], store_d[6], store_d[5], store_d[4]};

endmodule

// File: sv/sport_telemetry_frame_decoder.sv
// Top level of the sport telemetry frame decoder: byte input, decoded results out.
// Depends on stfd_pkg and stfd_deframer.
//
// Usage: the input channel carries one raw received byte per transfer on
// byte_in_i. The decoder hunts for the start byte, removes escapes and
// collects FRAME_BYTES frame bytes. A completed data frame yields one result
// transfer carrying the sensor id, data type, raw value, a known-type flag,
// the GPS position pair state and the GPS satellite count and fix. Other
// frames and all other bytes give no result.
// Throughput is one byte per cycle while in_ready_o is high. The transfer of a
// frame's last byte loads the frame register; the result then passes stage 2,
// which takes the GPS update and the reciprocal multiplier for the satellite
// count, and after that the output register.
// When the receiver stalls, results stay in the output register and the two
// stages behind it; in_ready_o drops once all three hold a result, whether or
// not the next byte would complete a frame, and rises again as soon as the
// receiver takes one.
// Reset (rst_ni low, asynchronous) returns the deframer to the start byte
// hunt, empties the pipeline and clears the stored latitude, longitude and
// their pending flags.
module sport_telemetry_frame_decoder import stfd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         sensor_id_o,
  output logic [15:0]        data_type_o,
  output logic [31:0]        raw_value_o,
  output logic               known_type_o,
  output logic               gps_pair_valid_o,
  output logic signed [30:0] latitude_o,
  output logic signed [30:0] longitude_o,
  output logic [6:0]         gps_satellites_o,
  output logic               gps_fix_o
);

  // Handshake chain: a stage may load when it is empty or its content moves on.
  logic   in_accept;
  logic   rdy1, rdy2, rdy3;
  frame_t frame;

  // Stage 1: completed data frame.
  logic        s1_v_q;
  logic [7:0]  s1_id_q;
  logic [15:0] s1_type_q;
  logic [31:0] s1_raw_q;

  // Stage 2: decoded fields and the quotient raw / 100.
  logic              s2_v_q;
  logic [7:0]        s2_id_q;
  logic [15:0]       s2_type_q;
  logic [31:0]       s2_raw_q;
  logic              s2_known_q;
  logic              s2_pair_q;
  logic [30:0]       s2_lat_q;
  logic [30:0]       s2_lon_q;
  logic              s2_state_q;
  logic              s2_fix_q;
  logic [QuotW-1:0]  s2_quot_q;

  // GPS position state.
  logic        is_lat;
  logic [30:0] lat_val_q, lat_val_d;
  logic [30:0] lon_val_q, lon_val_d;
  logic        lat_pend_q, lat_pend_d;
  logic        lon_pend_q, lon_pend_d;
  logic        pair;

  logic [29:0] gps_mag;
  logic [30:0] gps_sval;
  logic        is_pos;
  logic [63:0] div_prod;
  logic [31:0] quot_x100;
  logic [31:0] rem_full;

  // Output register.
  logic out_v_q;

  assign rdy3       = !out_v_q || out_ready_i;
  assign rdy2       = !s2_v_q || rdy3;
  assign rdy1       = !s1_v_q || rdy2;
  assign in_ready_o = rdy1;
  assign in_accept  = in_valid_i && rdy1;

  stfd_deframer #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_deframer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .byte_i  (byte_in_i),
    .frame_o (frame)
  );

  // Stage 1 holds a valid entry only for frames of the data type; the deframer raises done
  // only on a transfer, which in turn only happens while stage 1 can load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (rdy1) begin
      s1_v_q <= frame.done && frame.is_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && frame.done) begin
      s1_id_q   <= frame.sensor_id;
      s1_type_q <= frame.data_type;
      s1_raw_q  <= frame.raw_value;
    end
  end

  // GPS position update. The sign bit turns the 30-bit magnitude into its
  // 31-bit two's complement; a negative zero therefore stays zero.
  always_comb begin
    is_pos   = (s1_type_q == TypeGpsPos);
    gps_mag  = s1_raw_q[29:0] & GpsMagMask[29:0];
    gps_sval = s1_raw_q[GpsNegBit] ? (31'd0 - {1'b0, gps_mag}) : {1'b0, gps_mag};
    is_lat   = !s1_raw_q[GpsLonBit];

    lat_val_d  = lat_val_q;
    lon_val_d  = lon_val_q;
    lat_pend_d = lat_pend_q;
    lon_pend_d = lon_pend_q;
    pair       = 1'b0;
    if (is_pos) begin
      if (is_lat) begin
        lat_val_d  = gps_sval;
        lat_pend_d = 1'b1;
      end else begin
        lon_val_d  = gps_sval;
        lon_pend_d = 1'b1;
      end
      if (lat_pend_d && lon_pend_d) begin
        pair       = 1'b1;
        lat_pend_d = 1'b0;
        lon_pend_d = 1'b0;
      end
    end
  end

  // Quotient by 100 through the reciprocal; exact for every 32-bit value.
  assign div_prod = {32'd0, s1_raw_q} * {32'd0, Div100Mul};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q     <= 1'b0;
      lat_val_q  <= '0;
      lon_val_q  <= '0;
      lat_pend_q <= 1'b0;
      lon_pend_q <= 1'b0;
    end else if (rdy2) begin
      s2_v_q <= s1_v_q;
      if (s1_v_q) begin
        lat_val_q  <= lat_val_d;
        lon_val_q  <= lon_val_d;
        lat_pend_q <= lat_pend_d;
        lon_pend_q <= lon_pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && s1_v_q) begin
      s2_id_q    <= s1_id_q;
      s2_type_q  <= s1_type_q;
      s2_raw_q   <= s1_raw_q;
      s2_known_q <= is_known_type(s1_type_q);
      s2_pair_q  <= pair;
      s2_lat_q   <= lat_val_d;
      s2_lon_q   <= lon_val_d;
      s2_state_q <= (s1_type_q == TypeGpsState);
      s2_fix_q   <= (s1_raw_q > FixThreshold);
      s2_quot_q  <= div_prod[63:Div100Shift];
    end
  end

  // Remainder: raw minus quotient times 100, always below 100.
  assign quot_x100 = 32'({{(32 - QuotW){1'b0}}, s2_quot_q} * {25'd0, SatModulus});
  assign rem_full  = s2_raw_q - quot_x100;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy3) begin
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && s2_v_q) begin
      sensor_id_o      <= s2_id_q;
      data_type_o      <= s2_type_q;
      raw_value_o      <= s2_raw_q;
      known_type_o     <= s2_known_q;
      gps_pair_valid_o <= s2_pair_q;
      latitude_o       <= s2_lat_q;
      longitude_o      <= s2_lon_q;
      gps_satellites_o <= s2_state_q ? rem_full[6:0] : 7'd0;
      gps_fix_o        <= s2_state_q && s2_fix_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

// File: bench/sport_telemetry_frame_decoder_test.sv
// Self-checking bench for sport_telemetry_frame_decoder: framed byte stream in,
// decoded readings out. Needs stfd_pkg and the decoder RTL, nothing else.
`timescale 1ns / 100ps

module sport_telemetry_frame_decoder_test;
  import stfd_pkg::*;

  localparam int unsigned FrameBytes = 8;
  // Frame bytes (not idle noise) that the random part aims for.
  localparam int unsigned RandomBytes = 700;
  // Once fewer bytes than this are left to send, both sides stop idling.
  localparam int unsigned CalmTail = 120;
  localparam logic [15:0] KnownTypes [17] = '{
    16'h0210, 16'h0910, 16'h0110, 16'h0830, 16'h0100, 16'h0820, 16'h0420,
    16'h0600, 16'h0800, 16'h0200, 16'h0840, 16'hF101, 16'h0400, 16'h0410,
    16'h0430, 16'h0440, 16'h0A00
  };

  // One decoded reading, as the decoder presents it on its output ports.
  typedef struct packed {
    logic [7:0]  sensor_id;
    logic [15:0] data_type;
    logic [31:0] raw_value;
    logic        known_type;
    logic        gps_pair_valid;
    logic [30:0] latitude;
    logic [30:0] longitude;
    logic [6:0]  gps_satellites;
    logic        gps_fix;
  } reading_t;

  // Receive states of the deframer as the bench tracks it.
  typedef enum logic [1:0] {
    Hunt,
    Collect,
    Unescape
  } rx_state_e;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [7:0]         byte_in_i = 8'h00;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [7:0]         sensor_id_o;
  logic [15:0]        data_type_o;
  logic [31:0]        raw_value_o;
  logic               known_type_o;
  logic               gps_pair_valid_o;
  logic signed [30:0] latitude_o;
  logic signed [30:0] longitude_o;
  logic [6:0]         gps_satellites_o;
  logic               gps_fix_o;

  sport_telemetry_frame_decoder #(
    .FRAME_BYTES(FrameBytes)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .byte_in_i       (byte_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sensor_id_o     (sensor_id_o),
    .data_type_o     (data_type_o),
    .raw_value_o     (raw_value_o),
    .known_type_o    (known_type_o),
    .gps_pair_valid_o(gps_pair_valid_o),
    .latitude_o      (latitude_o),
    .longitude_o     (longitude_o),
    .gps_satellites_o(gps_satellites_o),
    .gps_fix_o       (gps_fix_o)
  );

  // Raw bytes still to be sent, and the readings the decoder still owes us.
  logic [7:0]  byte_stream[$];
  reading_t    expected_readings[$];
  int unsigned frame_bytes_queued = 0;
  int unsigned mismatches = 0;

  // Bench copy of the decoder state. The store starts at zero; the bench
  // never relies on that because a frame only completes once every stored
  // byte has been written since the last start byte.
  rx_state_e   rx_state = Hunt;
  int unsigned rx_count = 0;
  logic [7:0]  frame [StoreBytes];
  logic [30:0] stored_lat = '0;
  logic [30:0] stored_lon = '0;
  logic        lat_pending = 1'b0;
  logic        lon_pending = 1'b0;

  initial begin
    forever begin
      #6 clk_i = ~clk_i;
    end
  end

  initial begin
    foreach (frame[i]) frame[i] = 8'h00;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Bytes past the eighth are counted but never kept.
  task automatic keep_frame_byte(input logic [7:0] b);
    if (rx_count < StoreBytes) frame[rx_count] = b;
    rx_count++;
  endtask

  // Advances the bench deframer by one transferred byte and, when that byte
  // closes a data frame, queues the reading the decoder has to produce.
  task automatic track_telemetry_byte(input logic [7:0] b);
    logic [15:0] dtype;
    logic [31:0] raw;
    logic [30:0] mag;
    logic [30:0] pos;
    reading_t    r;
    case (rx_state)
      Hunt: begin
        rx_count = 0;
        if (b == StartByte) rx_state = Collect;
      end
      Collect: begin
        if (b == EscapeByte) rx_state = Unescape;
        else if (b == StartByte) rx_count = 0;
        else keep_frame_byte(b);
      end
      default: begin
        // The byte after an escape is always unescaped, even a start byte.
        keep_frame_byte(b ^ EscapeXor);
        rx_state = Collect;
      end
    endcase
    if (rx_count == FrameBytes) begin
      rx_state = Hunt;
      rx_count = 0;
      if (frame[1] == DataFrame) begin
        dtype = {frame[3], frame[2]};
        raw   = {frame[7], frame[6], frame[5], frame[4]};
        r = '0;
        if (dtype == TypeGpsPos) begin
          // Sign and magnitude to two's complement; a negative zero stays zero.
          mag = {1'b0, raw[29:0]};
          pos = raw[GpsNegBit] ? (~mag + 31'd1) : mag;
          if (!raw[GpsLonBit]) begin
            stored_lat  = pos;
            lat_pending = 1'b1;
          end else begin
            stored_lon  = pos;
            lon_pending = 1'b1;
          end
          if (lat_pending && lon_pending) begin
            lat_pending      = 1'b0;
            lon_pending      = 1'b0;
            r.gps_pair_valid = 1'b1;
          end
        end else if (dtype == TypeGpsState) begin
          r.gps_satellites = 7'(raw % 100);
          r.gps_fix        = raw > FixThreshold;
        end
        r.sensor_id = frame[0];
        r.data_type = dtype;
        r.raw_value = raw;
        foreach (KnownTypes[i]) begin
          if (KnownTypes[i] == dtype) r.known_type = 1'b1;
        end
        r.latitude  = stored_lat;
        r.longitude = stored_lon;
        expected_readings.push_back(r);
      end
    end
  endtask

  // Frame bytes that collide with the framing codes must be escaped; others
  // are escaped now and then, which the decoder has to undo as well.
  task automatic push_frame_byte(input logic [7:0] b, input int unsigned esc_pct);
    if (b == StartByte || b == EscapeByte || $urandom_range(0, 99) < esc_pct) begin
      byte_stream.push_back(EscapeByte);
      byte_stream.push_back(b ^ EscapeXor);
      frame_bytes_queued += 2;
    end else begin
      byte_stream.push_back(b);
      frame_bytes_queued++;
    end
  endtask

  // Queues a start byte and the first 'upto' bytes of a frame; a short frame
  // is simply cut off and restarted by the next start byte.
  task automatic push_frame(input logic [7:0] kind, input logic [15:0] dtype,
                            input logic [31:0] raw, input int unsigned upto);
    logic [7:0] body [9];
    body[0] = 8'($urandom);
    body[1] = kind;
    body[2] = dtype[7:0];
    body[3] = dtype[15:8];
    body[4] = raw[7:0];
    body[5] = raw[15:8];
    body[6] = raw[23:16];
    body[7] = raw[31:24];
    body[8] = 8'($urandom);
    byte_stream.push_back(StartByte);
    frame_bytes_queued++;
    for (int unsigned i = 0; i < upto; i++) push_frame_byte(body[i], 10);
  endtask

  // Stimulus: a short directed stream, then random frames, then the drain.
  initial begin
    int unsigned pick;
    logic [31:0] raw;
    logic [15:0] dtype;

    // Idle noise, including an escape byte that must be ignored in the hunt.
    byte_stream = '{8'h00, 8'hFF, EscapeByte};
    // A start byte inside a frame throws away the two bytes before it.
    byte_stream.push_back(StartByte);
    byte_stream.push_back(8'h12);
    byte_stream.push_back(DataFrame);
    byte_stream.push_back(StartByte);
    // Escaped start byte as sensor id, GPS latitude of negative zero.
    byte_stream.push_back(EscapeByte);
    byte_stream.push_back(StartByte ^ EscapeXor);
    byte_stream.push_back(DataFrame);
    byte_stream.push_back(TypeGpsPos[7:0]);
    byte_stream.push_back(TypeGpsPos[15:8]);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'h00);
    byte_stream.push_back(8'h40);
    // An escape followed by a raw escape byte, then a GPS state frame with an
    // all-ones value: a count of 95, with a fix.
    byte_stream.push_back(StartByte);
    byte_stream.push_back(EscapeByte);
    byte_stream.push_back(EscapeByte);
    byte_stream.push_back(DataFrame);
    byte_stream.push_back(TypeGpsState[7:0]);
    byte_stream.push_back(TypeGpsState[15:8]);
    repeat (4) byte_stream.push_back(8'hFF);
    frame_bytes_queued = 0;

    while (frame_bytes_queued < RandomBytes) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // Well-formed data frame; most of the run.
        raw = $urandom;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5: begin
            dtype = TypeGpsPos;
            case ($urandom_range(0, 3))
              0: raw[29:0] = '0;
              1: raw[29:0] = '1;
              default: ;
            endcase
          end
          6, 7, 8: begin
            dtype = TypeGpsState;
            case ($urandom_range(0, 3))
              0: raw = 32'($urandom_range(0, 2000));
              1: raw = FixThreshold + 32'($urandom_range(0, 1));
              2: raw = $urandom_range(0, 1) ? 32'd0 : 32'hFFFF_FFFF;
              default: ;
            endcase
          end
          9, 10, 11, 12, 13, 14, 15: dtype = KnownTypes[$urandom_range(0, 16)];
          default: dtype = 16'($urandom);
        endcase
        push_frame(DataFrame, dtype, raw, FrameBytes);
      end else if (pick < 90) begin
        // A random frame type, mostly not the data type; those give no reading.
        push_frame(8'($urandom_range(0, 255)) ^ ($urandom_range(0, 1) ? 8'h00 : DataFrame),
                   16'($urandom), $urandom, FrameBytes);
      end else if (pick < 95) begin
        // Cut-off frame, restarted by whatever start byte comes next.
        push_frame(DataFrame, 16'($urandom), $urandom, $urandom_range(0, FrameBytes - 1));
        if ($urandom_range(0, 1)) byte_stream.push_back(EscapeByte);
      end else begin
        // Line noise between frames.
        repeat ($urandom_range(1, 5)) byte_stream.push_back(8'($urandom));
      end
    end

    while (byte_stream.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_readings.size() > 0) @(posedge clk_i);
    // Three pipeline stages; give a stray reading time to show up.
    repeat (12) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // Byte sender: holds each byte until its transfer, idles in random bursts
  // except near the end of the stream.
  int unsigned send_idle = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) track_telemetry_byte(byte_in_i);
      if (!in_valid_i || in_ready_o) begin
        if (send_idle > 0) begin
          send_idle--;
          in_valid_i <= 1'b0;
        end else if (byte_stream.size() > 0) begin
          in_valid_i <= 1'b1;
          byte_in_i  <= byte_stream.pop_front();
          if (byte_stream.size() > CalmTail && $urandom_range(0, 7) == 0)
            send_idle = $urandom_range(1, 12);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Reading receiver: stalls in random bursts, and checks every transfer
  // against the oldest reading still owed.
  int unsigned recv_stall = 0;
  reading_t    got_reading;
  reading_t    want_reading;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_reading = '{sensor_id_o, data_type_o, raw_value_o, known_type_o,
                        gps_pair_valid_o, latitude_o, longitude_o,
                        gps_satellites_o, gps_fix_o};
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, expected none, actual %h", $time,
                   got_reading);
          mismatches++;
        end else begin
          want_reading = expected_readings.pop_front();
          check_field("sensor_id", 32'(want_reading.sensor_id), 32'(got_reading.sensor_id));
          check_field("data_type", 32'(want_reading.data_type), 32'(got_reading.data_type));
          check_field("raw_value", want_reading.raw_value, got_reading.raw_value);
          check_field("known_type", 32'(want_reading.known_type),
                      32'(got_reading.known_type));
          check_field("gps_pair_valid", 32'(want_reading.gps_pair_valid),
                      32'(got_reading.gps_pair_valid));
          check_field("latitude", 32'(want_reading.latitude), 32'(got_reading.latitude));
          check_field("longitude", 32'(want_reading.longitude),
                      32'(got_reading.longitude));
          check_field("gps_satellites", 32'(want_reading.gps_satellites),
                      32'(got_reading.gps_satellites));
          check_field("gps_fix", 32'(want_reading.gps_fix), 32'(got_reading.gps_fix));
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (byte_stream.size() > CalmTail && $urandom_range(0, 9) == 0)
          recv_stall = $urandom_range(1, 12);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sport_telemetry_frame_decoder.f
sv/stfd_pkg.sv
sv/stfd_deframer.sv
sv/sport_telemetry_frame_decoder.sv
bench/sport_telemetry_frame_decoder_test.sv
